// ===== rtl/iiel_pkg.sv =====
// Shared types and codes for the indexed insert/erase list.
package iiel_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LenW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_ERASE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DataW-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== rtl/iiel_req_if.sv =====
// Request channel: operation, position and value with valid/ready.
interface iiel_req_if;
  logic                                valid;
  logic                                ready;
  logic [iiel_pkg::OpW-1:0]            op;
  logic [iiel_pkg::PosW-1:0]           position;
  logic signed [iiel_pkg::DataW-1:0]   item_value;

  modport source (output valid, output op, output position, output item_value, input ready);
  modport sink   (input valid, input op, input position, input item_value, output ready);
endinterface

// Response channel: status, read value, length and empty flag with valid/ready.
interface iiel_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [iiel_pkg::StatW-1:0]          status;
  logic signed [iiel_pkg::DataW-1:0]   read_value;
  logic [iiel_pkg::LenW-1:0]           length;
  logic                                is_empty;

  modport source (output valid, output status, output read_value, output length,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input read_value, input length,
                  input is_empty, output ready);
endinterface

// ===== rtl/indexed_insert_erase_list_core.sv =====
// Top level: control, row of list cells and registered response stage.
// A request accepted at a clock edge has its response registered and valid from that same edge.
// Throughput: one request per cycle while responses are taken; every cell of the row shifts in that same cycle.
// The response register frees the request side whenever the response is taken.
// Reset clears the entry count and the response valid; cell contents need no reset.
module indexed_insert_erase_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  iiel_req_if.sink       req,
  iiel_rsp_if.source     rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned WW = (CW > iiel_pkg::PosW) ? CW : iiel_pkg::PosW;
  localparam logic [WW-1:0] CapW = WW'(CAPACITY);

  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [WW-1:0]                count_w;
  logic [WW-1:0]                pos_w;
  logic [WW-1:0]                cnt_next_w;
  logic                         full;
  logic                         accept;
  iiel_pkg::status_t            status_next;
  logic [iiel_pkg::DataW-1:0]   rd_next;
  iiel_pkg::cell_cmd_t          cmd;
  logic [WW-1:0]                target;
  logic [iiel_pkg::DataW-1:0]   entry [CAPACITY];

  assign count_w  = WW'(count);
  assign pos_w    = WW'(req.position);
  assign full     = (count_w >= CapW);
  assign accept   = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  always_comb begin
    status_next = iiel_pkg::ST_OK;
    rd_next     = '0;
    count_next  = count;
    cmd.op      = iiel_pkg::CELL_HOLD;
    cmd.value   = req.item_value;
    target      = pos_w;
    unique case (req.op)
      iiel_pkg::OP_APPEND: begin
        target = count_w;
        if (full) begin
          status_next = iiel_pkg::ST_FULL;
        end else begin
          cmd.op     = iiel_pkg::CELL_LOAD;
          count_next = count + CW'(1);
        end
      end
      iiel_pkg::OP_POP: begin
        if (count == '0) begin
          status_next = iiel_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      iiel_pkg::OP_INSERT: begin
        if (pos_w > count_w) begin
          status_next = iiel_pkg::ST_RANGE;
        end else if (full) begin
          status_next = iiel_pkg::ST_FULL;
        end else begin
          cmd.op     = iiel_pkg::CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      iiel_pkg::OP_ERASE: begin
        if (pos_w >= count_w) begin
          status_next = iiel_pkg::ST_RANGE;
        end else begin
          cmd.op     = iiel_pkg::CELL_ERASE;
          count_next = count - CW'(1);
        end
      end
      iiel_pkg::OP_READ: begin
        if (pos_w >= count_w) begin
          status_next = iiel_pkg::ST_RANGE;
        end else begin
          rd_next = entry[pos_w[AW-1:0]];
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.op     = iiel_pkg::CELL_HOLD;
      count_next = count;
    end
  end

  assign cnt_next_w = WW'(count_next);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [iiel_pkg::DataW-1:0] left_v;
    logic [iiel_pkg::DataW-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = entry[i];
    end else begin : g_mid_r
      assign right_v = entry[i+1];
    end
    iiel_cell #(
      .IDX (i),
      .WW  (WW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .target      (target),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status     <= status_next;
      rsp.read_value <= rd_next;
      rsp.length     <= cnt_next_w[iiel_pkg::LenW-1:0];
      rsp.is_empty   <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= CapW)
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    accept && req.op == iiel_pkg::OP_APPEND && !full |=> count == CW'($past(count) + 1))
    else $error("append did not grow the list by one");

  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && status_next != iiel_pkg::ST_OK |=> count == $past(count))
    else $error("failed request changed the entry count");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while response beat stalled");

endmodule

// ===== rtl/iiel_cell.sv =====
// One storage cell of the list: holds an entry and shifts with its neighbors.
module iiel_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned WW  = 5
) (
  input  logic                          clk,
  input  iiel_pkg::cell_cmd_t           cmd,
  input  logic [WW-1:0]                 target,
  input  logic [iiel_pkg::DataW-1:0]    left_value,
  input  logic [iiel_pkg::DataW-1:0]    right_value,
  output logic [iiel_pkg::DataW-1:0]    value
);

  localparam logic [WW-1:0] MyIdx = WW'(IDX);

  logic [iiel_pkg::DataW-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      iiel_pkg::CELL_HOLD: value_next = value;
      iiel_pkg::CELL_LOAD: begin
        if (MyIdx == target) value_next = cmd.value;
      end
      iiel_pkg::CELL_INSERT: begin
        // Cells above the insert point take the entry from below.
        if (MyIdx > target) value_next = left_value;
        else if (MyIdx == target) value_next = cmd.value;
      end
      iiel_pkg::CELL_ERASE: begin
        if (MyIdx >= target) value_next = right_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== dv/indexed_insert_erase_list_core_tb.sv =====
// Testbench for the indexed insert/erase list: directed and random requests vs a shadow list.
module indexed_insert_erase_list_core_tb;
  import iiel_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomRequests = 1950;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainCycles = 4;
  localparam logic [OpW-1:0] OpUnusedFirst = OpW'(OP_READ + 1);
  localparam logic [OpW-1:0] OpUnusedLast = '1;

  typedef struct {
    status_t                  status;
    logic signed [DataW-1:0]  read_value;
    logic [LenW-1:0]          length;
    logic                     is_empty;
  } list_rsp_t;

  class list_scoreboard;
    logic signed [DataW-1:0] shadow_entries[Capacity];
    int unsigned shadow_count;
    list_rsp_t expected_rsps[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned op_seen[2**OpW];
    int unsigned status_seen[2**StatW];
    int unsigned full_hits;

    function new();
      shadow_count = 0;
      mismatches = 0;
      checked = 0;
      full_hits = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned occupancy();
      return shadow_count;
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction

    // Applies one accepted request to the shadow list and queues its response.
    function void note_request(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                               logic signed [DataW-1:0] value);
      list_rsp_t rsp;
      int unsigned idx;
      rsp.status = ST_OK;
      rsp.read_value = '0;
      idx = 32'(pos);
      case (op)
        OP_APPEND: begin
          if (shadow_count >= Capacity) begin
            rsp.status = ST_FULL;
          end else begin
            shadow_entries[shadow_count] = value;
            shadow_count++;
          end
        end
        OP_POP: begin
          if (shadow_count == 0) rsp.status = ST_EMPTY;
          else shadow_count--;
        end
        OP_INSERT: begin
          // The index check wins over the full check.
          if (idx > shadow_count) begin
            rsp.status = ST_RANGE;
          end else if (shadow_count >= Capacity) begin
            rsp.status = ST_FULL;
          end else begin
            for (int unsigned i = shadow_count; i > idx; i--)
              shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[idx] = value;
            shadow_count++;
          end
        end
        OP_ERASE: begin
          if (idx >= shadow_count) begin
            rsp.status = ST_RANGE;
          end else begin
            for (int unsigned i = idx; i + 1 < shadow_count; i++)
              shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
          end
        end
        OP_READ: begin
          if (idx >= shadow_count) rsp.status = ST_RANGE;
          else rsp.read_value = shadow_entries[idx];
        end
        default: begin
        end
      endcase
      rsp.length = shadow_count[LenW-1:0];
      rsp.is_empty = (shadow_count == 0);
      if (shadow_count == Capacity && rsp.status == ST_OK &&
          (op == OP_APPEND || op == OP_INSERT))
        full_hits++;
      op_seen[op]++;
      expected_rsps.push_back(rsp);
    endfunction

    task report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
      mismatches++;
      $display("MISMATCH response %0d: %s got 0x%0h expected 0x%0h",
               checked, what, got, want);
    endtask

    task check_response(logic [StatW-1:0] status, logic signed [DataW-1:0] read_value,
                        logic [LenW-1:0] length, logic is_empty);
      list_rsp_t want;
      if (expected_rsps.size() == 0) begin
        report_mismatch("beat with no request outstanding, status",
                        DataW'(status), '0);
      end else begin
        want = expected_rsps.pop_front();
        if (status !== want.status)
          report_mismatch("status", DataW'(status), DataW'(want.status));
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (length !== want.length)
          report_mismatch("length", DataW'(length), DataW'(want.length));
        if (is_empty !== want.is_empty)
          report_mismatch("is_empty", DataW'(is_empty), DataW'(want.is_empty));
        status_seen[want.status]++;
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  iiel_req_if req_bus();
  iiel_rsp_if rsp_bus();

  list_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  indexed_insert_erase_list_core #(.CAPACITY(Capacity)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response side: checks every accepted beat and drives ready, including one long hold-off.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready)
        sb.check_response(rsp_bus.status, rsp_bus.read_value, rsp_bus.length,
                          rsp_bus.is_empty);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HoldOffCycles;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic send_request(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                              input logic signed [DataW-1:0] value);
    if (!calm && $urandom_range(99) < 12) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.position <= pos;
    req_bus.item_value <= value;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(op, pos, value);
  endtask

  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly in-range positions for the current fill, the rest anywhere in the field.
  function automatic logic [PosW-1:0] pick_position(logic [OpW-1:0] op, int unsigned count);
    if ($urandom_range(99) < 80) begin
      if (op == OP_INSERT) return PosW'($urandom_range(count, 0));
      if (op == OP_ERASE || op == OP_READ) begin
        if (count == 0) return '0;
        return PosW'($urandom_range(count - 1, 0));
      end
    end
    return PosW'($urandom());
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0: return {1'b0, {(DataW-1){1'b1}}};
      1: return {1'b1, {(DataW-1){1'b0}}};
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    bit filling;
    int unsigned roll;
    int unsigned unused_total;
    logic [OpW-1:0] op;

    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.op <= OP_APPEND;
    req_bus.position <= '0;
    req_bus.item_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Error cases on the empty list first, then edits at both ends and in the middle.
    send_request(OP_POP, '0, '0);
    send_request(OP_ERASE, '0, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_INSERT, PosW'(1), 32'h1111_1111);
    send_request(OP_INSERT, '0, 32'h7FFF_FFFF);
    send_request(OP_APPEND, '1, 32'h8000_0000);
    send_request(OP_APPEND, '0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, PosW'(1), 32'h0000_0000);
    send_request(OP_INSERT, PosW'(sb.occupancy()), 32'h5A5A_A5A5);
    send_request(OP_INSERT, PosW'(sb.occupancy() + 1), 32'h2222_2222);
    send_request(OP_READ, '0, '0);
    send_request(OP_READ, PosW'(sb.occupancy() - 1), '0);
    send_request(OP_READ, '1, '0);
    send_request(OP_ERASE, PosW'(1), '0);
    send_request(OP_ERASE, PosW'(sb.occupancy() - 1), '0);
    send_request(OP_POP, '0, '0);
    for (int unsigned u = OpUnusedFirst; u <= OpUnusedLast; u++)
      send_request(OpW'(u), '1, '1);

    // Alternate between filling and draining so full and empty are both hit often.
    filling = 1'b1;
    for (int unsigned n = 0; n < RandomRequests; n++) begin
      if (n == 300) hold_off_req = 1'b1;
      calm = (n >= 600 && n < 900);
      if (n == 1200) wait_for_drain();
      if (filling && sb.occupancy() == Capacity && $urandom_range(3) == 0) filling = 1'b0;
      if (!filling && sb.occupancy() == 0 && $urandom_range(3) == 0) filling = 1'b1;
      roll = $urandom_range(99);
      if (roll < 3) op = OpW'($urandom_range(OpUnusedLast, OpUnusedFirst));
      else if (roll < (filling ? 33 : 13)) op = OP_APPEND;
      else if (roll < (filling ? 63 : 23)) op = OP_INSERT;
      else if (roll < (filling ? 71 : 48)) op = OP_POP;
      else if (roll < (filling ? 79 : 73)) op = OP_ERASE;
      else op = OP_READ;
      send_request(op, pick_position(op, sb.occupancy()), pick_value());
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);

    unused_total = 0;
    for (int unsigned u = OpUnusedFirst; u <= OpUnusedLast; u++)
      unused_total += sb.op_seen[u];
    $display("Checked %0d: %0d append, %0d pop, %0d insert, %0d erase, %0d read, %0d unused op",
             sb.checked, sb.op_seen[OP_APPEND], sb.op_seen[OP_POP], sb.op_seen[OP_INSERT],
             sb.op_seen[OP_ERASE], sb.op_seen[OP_READ], unused_total);
    $display("Status: %0d ok, %0d range, %0d empty, %0d full; list filled %0d times",
             sb.status_seen[ST_OK], sb.status_seen[ST_RANGE], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FULL], sb.full_hits);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
